### rtl/exponential_search_assert.svh
// Assertion macros shared by the checker files of the exponential search block.
// Each macro expands to one labeled concurrent assertion on the rising edge of clk.
`ifndef EXPONENTIAL_SEARCH_ASSERT_SVH
`define EXPONENTIAL_SEARCH_ASSERT_SVH

// Implication that is not checked while rst is high.
`define ES_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked during reset.
`define ES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/es_pkg.sv
// ---------------------------------------------------------------------------
// es_pkg: shared definitions of the exponential search block
// Widths, operation codes, state encoding and the command and status
// structs between the controller and the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package es_pkg;

  // Fixed field widths.
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned DEPTH_DEF = 1024;

  // Operation codes of an input item.
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_SEARCH = 2'd1,
    OP_CLEAR  = 2'd2
  } es_op_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK0,
    ST_DBL,
    ST_BS_SET,
    ST_BS_RD,
    ST_BS_CMP,
    ST_FIN
  } es_state_t;

  // Read address sources.
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_ONE,
    RD_DBL,
    RD_MID
  } es_rd_sel_t;

  // Kinds of search result.
  typedef enum logic [1:0] {
    RES_MISS,
    RES_FIRST,
    RES_MID
  } es_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       append;
    logic       clear;
    logic       load_key;
    logic       rd_en;
    es_rd_sel_t rd_sel;
    logic       i_init;
    logic       i_double;
    logic       bs_init;
    logic       mid_load;
    logic       lo_up;
    logic       hi_down;
    logic       pend_set;
    es_res_t    pend_kind;
    logic       out_load;
  } es_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic n_gt_one;
    logic eq;
    logic lt;
    logic dbl_lt_n;
    logic mid_eq_lo;
    logic mid_eq_hi;
    logic out_free;
  } es_stat_t;

endpackage

`default_nettype wire

### rtl/es_if.sv
// ---------------------------------------------------------------------------
// es_in_if / es_out_if: item channels of the exponential search block
// Valid/ready channels; an item moves when valid and ready are both high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface es_in_if import es_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

interface es_out_if import es_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;

  modport source (output valid, output found, output position, input ready);
  modport sink (input valid, input found, input position, output ready);
endinterface

`default_nettype wire

### rtl/es_ctrl.sv
// ---------------------------------------------------------------------------
// es_ctrl: controller of the exponential search block
// Sequences the first-element check, the doubling phase and the binary
// search, one memory read per step, and hands the result to the output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module es_ctrl import es_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_ready,
  output es_cmd_t         cmd,
  input  es_stat_t        stat
);

  es_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Items are taken only in the idle state.
  assign in_ready = (state == ST_IDLE) && !rst;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          unique case (es_op_t'(in_op))
            OP_APPEND: cmd.append = 1'b1;
            OP_CLEAR:  cmd.clear  = 1'b1;
            OP_SEARCH: begin
              cmd.load_key = 1'b1;
              if (stat.count_zero) begin
                cmd.pend_set  = 1'b1;
                cmd.pend_kind = RES_MISS;
                state_next    = ST_FIN;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_ZERO;
                state_next = ST_CHK0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CHK0: begin
        // The first element answers position zero on a match.
        if (stat.eq) begin
          cmd.pend_set  = 1'b1;
          cmd.pend_kind = RES_FIRST;
          state_next    = ST_FIN;
        end else begin
          cmd.i_init = 1'b1;
          if (stat.n_gt_one) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_ONE;
            state_next = ST_DBL;
          end else begin
            state_next = ST_BS_SET;
          end
        end
      end
      ST_DBL: begin
        // Double the bound while the element there is at most the key.
        if (stat.eq || stat.lt) begin
          cmd.i_double = 1'b1;
          if (stat.dbl_lt_n) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_DBL;
          end else begin
            state_next = ST_BS_SET;
          end
        end else begin
          state_next = ST_BS_SET;
        end
      end
      ST_BS_SET: begin
        cmd.bs_init = 1'b1;
        state_next  = ST_BS_RD;
      end
      ST_BS_RD: begin
        cmd.mid_load = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_MID;
        state_next   = ST_BS_CMP;
      end
      ST_BS_CMP: begin
        // Narrow the window; an empty window means the key is absent.
        if (stat.eq) begin
          cmd.pend_set  = 1'b1;
          cmd.pend_kind = RES_MID;
          state_next    = ST_FIN;
        end else if (stat.lt) begin
          if (stat.mid_eq_hi) begin
            cmd.pend_set  = 1'b1;
            cmd.pend_kind = RES_MISS;
            state_next    = ST_FIN;
          end else begin
            cmd.lo_up  = 1'b1;
            state_next = ST_BS_RD;
          end
        end else begin
          if (stat.mid_eq_lo) begin
            cmd.pend_set  = 1'b1;
            cmd.pend_kind = RES_MISS;
            state_next    = ST_FIN;
          end else begin
            cmd.hi_down = 1'b1;
            state_next  = ST_BS_RD;
          end
        end
      end
      ST_FIN: begin
        // Wait for the output register to be free.
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/es_datapath.sv
// ---------------------------------------------------------------------------
// es_datapath: storage and arithmetic of the exponential search block
// Holds the element memory, the count, the key, the search bound and the
// binary-search window, and the output register of the result channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module es_datapath import es_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  es_cmd_t                   cmd,
  output es_stat_t                  stat,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic                      out_found,
  output logic [POS_W-1:0]          out_position
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned IW = CW + 1;

  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] rdata;
  logic signed [VALUE_W-1:0] key;
  logic [CW-1:0]             count;
  logic [CW-1:0]             count_m1;
  logic [IW-1:0]             bound;
  logic [IW-1:0]             bound_dbl;
  logic [AW-1:0]             lo;
  logic [AW-1:0]             hi;
  logic [AW-1:0]             mid;
  logic [AW-1:0]             mid_calc;
  logic [AW:0]               mid_sum;
  logic [AW-1:0]             rd_addr;
  logic                      full;
  logic                      pend_found;
  logic [POS_W-1:0]          pend_pos;

  assign full      = (count == CW'(DEPTH));
  assign count_m1  = count - CW'(1);
  assign bound_dbl = IW'(bound << 1);
  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid_calc  = mid_sum[AW:1];

  // Read address selection.
  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO: rd_addr = '0;
      RD_ONE:  rd_addr = AW'(1);
      RD_DBL:  rd_addr = AW'(bound_dbl);
      RD_MID:  rd_addr = mid_calc;
      default: rd_addr = '0;
    endcase
  end

  // Element memory: appends at the count, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      mem[count[AW-1:0]] <= in_value;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Element count.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
    end else if (cmd.append && !full) begin
      count <= count + CW'(1);
    end
  end

  // Key, bound and binary-search window.
  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key <= in_value;
    end
    if (cmd.i_init) begin
      bound <= IW'(1);
    end else if (cmd.i_double) begin
      bound <= bound_dbl;
    end
    if (cmd.bs_init) begin
      lo <= AW'(bound >> 1);
      hi <= (bound < {1'b0, count_m1}) ? AW'(bound) : AW'(count_m1);
    end else if (cmd.lo_up) begin
      lo <= mid + AW'(1);
    end else if (cmd.hi_down) begin
      hi <= mid - AW'(1);
    end
    if (cmd.mid_load) begin
      mid <= mid_calc;
    end
  end

  // Pending result of the current search.
  always_ff @(posedge clk) begin
    if (cmd.pend_set) begin
      case (cmd.pend_kind)
        RES_FIRST: begin
          pend_found <= 1'b1;
          pend_pos   <= '0;
        end
        RES_MID: begin
          pend_found <= 1'b1;
          pend_pos   <= POS_W'(mid);
        end
        default: begin
          pend_found <= 1'b0;
          pend_pos   <= '0;
        end
      endcase
    end
  end

  // Output register of the result channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found    <= pend_found;
      out_position <= pend_pos;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.count_zero = (count == '0);
    stat.n_gt_one   = (count > CW'(1));
    stat.eq         = (rdata == key);
    stat.lt         = (rdata < key);
    stat.dbl_lt_n   = (bound_dbl < {1'b0, count});
    stat.mid_eq_lo  = (mid == lo);
    stat.mid_eq_hi  = (mid == hi);
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

### rtl/exponential_search.sv
// Append and clear items may follow back to back.
// A search makes D doubling reads and B binary-search steps, each at most
// log2 DEPTH; a stalled result register holds the search until it frees,
// and the next item is taken once the result is loaded. One read per step.
// Reset empties the store at once; memory contents are kept, no clearing pass.
// ---------------------------------------------------------------------------
// exponential_search: sorted store with exponential search
// Top level: joins the controller and the datapath to the item channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module exponential_search import es_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  es_in_if.sink    req,
  es_out_if.source resp
);

  es_cmd_t  cmd;
  es_stat_t stat;

  // Sequencer.
  es_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_op    (req.op),
    .in_ready (req.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Storage and compare logic.
  es_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_value     (req.value),
    .out_ready    (resp.ready),
    .out_valid    (resp.valid),
    .out_found    (resp.found),
    .out_position (resp.position)
  );

endmodule

`default_nettype wire

### rtl/es_checker.sv
// ---------------------------------------------------------------------------
// es_checker: port checks of the exponential search block
// Watches the item channels of the top level over time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "exponential_search_assert.svh"

module es_checker import es_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_ready,
  input logic             resp_valid,
  input logic             resp_ready,
  input logic             resp_found,
  input logic [POS_W-1:0] resp_position
);

  // A stalled result item holds its value.
  `ES_ASSERT_NEXT(a_resp_hold, !rst && resp_valid && !resp_ready, rst || (resp_valid && $stable(resp_found) && $stable(resp_position)), "result item changed while stalled")

  // A miss always reports position zero.
  `ES_ASSERT_IMP(a_miss_pos, resp_valid && !resp_found, resp_position == '0, "miss with nonzero position")

  // A new result comes only out of a running search, never from idle.
  `ES_ASSERT_IMP(a_rose_busy, $rose(resp_valid), !$past(req_ready), "result appeared while idle")

  // Reset empties the result register.
  `ES_ASSERT_NEXT(a_reset_clear, rst, !resp_valid, "result valid after reset")

endmodule

bind exponential_search es_checker u_es_checker (
  .clk           (clk),
  .rst           (rst),
  .req_ready     (req.ready),
  .resp_valid    (resp.valid),
  .resp_ready    (resp.ready),
  .resp_found    (resp.found),
  .resp_position (resp.position)
);

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking testbench of the exponential search block
// A short table of directed items is followed by random batches of sorted
// appends and searches, a full-store fill, and sender and receiver idling.
// Each search result is compared with a predictor that keeps its own copy
// of the stored array and element count.
// ---------------------------------------------------------------------------

module tb;
  import es_pkg::*;

  localparam int unsigned STORE_DEPTH = DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned DRAIN_WAIT  = 100;
  localparam int unsigned MAX_REPORTS = 50;

  // The op field has one code that the block ignores.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // One expected search answer.
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } lookup_t;

  // One row of the directed table; the answer is typed in only where marked.
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic               typed;
    logic               found;
    logic [POS_W-1:0]   position;
  } directed_row_t;

  localparam int unsigned NUM_DIRECTED = 23;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{OP_SEARCH, 32'h0000_0000, 1'b1, 1'b0, 10'd0},  // empty store
    '{OP_UNUSED, 32'h1234_5678, 1'b0, 1'b0, 10'd0},  // ignored op code
    '{OP_SEARCH, 32'h1234_5678, 1'b1, 1'b0, 10'd0},  // still empty
    '{OP_APPEND, 32'h8000_0000, 1'b0, 1'b0, 10'd0},
    '{OP_SEARCH, 32'h8000_0000, 1'b1, 1'b1, 10'd0},  // match at the first element
    '{OP_SEARCH, 32'h7fff_ffff, 1'b0, 1'b0, 10'd0},
    '{OP_APPEND, 32'hffff_fffb, 1'b0, 1'b0, 10'd0},
    '{OP_APPEND, 32'h0000_0000, 1'b0, 1'b0, 10'd0},
    '{OP_APPEND, 32'h0000_0007, 1'b0, 1'b0, 10'd0},
    '{OP_APPEND, 32'h7fff_ffff, 1'b0, 1'b0, 10'd0},
    '{OP_SEARCH, 32'h7fff_ffff, 1'b0, 1'b0, 10'd0},
    '{OP_SEARCH, 32'h0000_0007, 1'b0, 1'b0, 10'd0},
    '{OP_SEARCH, 32'h0000_0003, 1'b1, 1'b0, 10'd0},  // key not present
    '{OP_SEARCH, 32'hffff_ffff, 1'b0, 1'b0, 10'd0},
    '{OP_APPEND, 32'h0000_0064, 1'b0, 1'b0, 10'd0},  // breaks the order
    '{OP_SEARCH, 32'h0000_0064, 1'b0, 1'b0, 10'd0},
    '{OP_SEARCH, 32'h8000_0000, 1'b1, 1'b1, 10'd0},
    '{OP_CLEAR,  32'hffff_ffff, 1'b0, 1'b0, 10'd0},
    '{OP_SEARCH, 32'h0000_0000, 1'b1, 1'b0, 10'd0},  // empty after clear
    '{OP_APPEND, 32'hffff_ffff, 1'b0, 1'b0, 10'd0},
    '{OP_SEARCH, 32'hffff_ffff, 1'b1, 1'b1, 10'd0},
    '{OP_CLEAR,  32'h0000_0000, 1'b0, 1'b0, 10'd0},
    '{OP_UNUSED, 32'h0000_0000, 1'b0, 1'b0, 10'd0}
  };

  logic clk;
  logic rst;

  es_in_if  req ();
  es_out_if resp ();

  exponential_search dut (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .resp (resp)
  );

  // Predictor state: the stored elements and their count.
  logic signed [VALUE_W-1:0] model_store [STORE_DEPTH];
  int unsigned               model_count;

  // Answers still to come, oldest first.
  lookup_t expected_answers [$];

  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned items_sent;

  // Idling controls; the percentages and the hold request are set at a rising edge.
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  bit          hold_req;
  int unsigned hold_left;

  // Answer typed in the directed table for the item on the channel.
  bit               typed_on;
  logic             typed_found;
  logic [POS_W-1:0] typed_position;

  // Clock.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d answers outstanding", cycle_count,
               expected_answers.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Exponential search over the predictor's copy of the store.
  function automatic lookup_t lookup_key(input logic signed [VALUE_W-1:0] key);
    lookup_t answer;
    int      bound;
    int      lo;
    int      hi;
    int      mid;
    answer = '0;
    if (model_count == 0) begin
      return answer;
    end
    if (model_store[0] == key) begin
      answer.found = 1'b1;
      return answer;
    end
    bound = 1;
    while (bound < int'(model_count) && model_store[bound] <= key) begin
      bound = bound * 2;
    end
    hi = (bound < int'(model_count) - 1) ? bound : int'(model_count) - 1;
    lo = bound / 2;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (model_store[mid] == key) begin
        answer.found    = 1'b1;
        answer.position = mid[POS_W-1:0];
        return answer;
      end
      if (model_store[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return answer;
  endfunction

  // Apply one accepted item to the predictor and queue its answer, if any.
  function automatic void apply_item(input logic [OP_W-1:0] op,
                                     input logic signed [VALUE_W-1:0] value);
    lookup_t answer;
    case (op)
      OP_APPEND: begin
        if (model_count < STORE_DEPTH) begin
          model_store[model_count] = value;
          model_count++;
        end
      end
      OP_SEARCH: begin
        answer = lookup_key(value);
        if (typed_on) begin
          answer.found    = typed_found;
          answer.position = typed_position;
        end
        expected_answers.push_back(answer);
      end
      OP_CLEAR: begin
        model_count = 0;
      end
      default: begin
      end
    endcase
  endfunction

  // Input monitor: every accepted item goes through the predictor.
  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) begin
      apply_item(req.op, req.value);
    end
  end

  // Output monitor: every accepted result is checked against the oldest answer.
  always @(posedge clk) begin : check_results
    lookup_t want;
    if (!rst && resp.valid && resp.ready) begin
      if (expected_answers.size() == 0) begin
        report_mismatch($sformatf("result with none expected: found=%0b position=%0d",
                                  resp.found, resp.position));
      end else begin
        want = expected_answers.pop_front();
        if (resp.found !== want.found) begin
          report_mismatch($sformatf("found is %0b, expected %0b", resp.found, want.found));
        end
        if (resp.position !== want.position) begin
          report_mismatch($sformatf("position is %0d, expected %0d", resp.position,
                                    want.position));
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off counted here when requested.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      resp.ready = 1'b0;
      hold_left--;
    end else begin
      resp.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one item, with random idle cycles first; returns at a falling edge.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                           input bit typed = 1'b0, input logic hit = 1'b0,
                           input logic [POS_W-1:0] pos = '0);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid      = 1'b1;
    req.op         = op;
    req.value      = value;
    typed_on       = typed;
    typed_found    = hit;
    typed_position = pos;
    do begin
      @(posedge clk);
    end while (!req.ready);
    items_sent++;
    @(negedge clk);
  endtask

  // Let the sender rest until every answer has come back.
  task automatic wait_drain();
    req.valid = 1'b0;
    while (expected_answers.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
    @(posedge clk);
    send_idle_pct = sender_pct;
    stall_pct     = receiver_pct;
    @(negedge clk);
  endtask

  // A batch: usually a clear, sorted appends, then searches for present and
  // absent keys, with ignored op codes and out-of-order appends mixed in.
  task automatic run_sorted_batch();
    int vals [$];
    int n;
    int m;
    int pick;
    int key;
    bit narrow;
    if ($urandom_range(9) != 0) begin
      send_item(OP_CLEAR, $urandom);
    end
    pick = $urandom_range(99);
    if (pick < 5) begin
      n = 0;
    end else if (pick < 92) begin
      n = $urandom_range(32, 1);
    end else begin
      n = $urandom_range(200, 33);
    end
    narrow = ($urandom_range(2) == 0);
    for (int i = 0; i < n; i++) begin
      vals.push_back(narrow ? int'($urandom_range(128)) - 64 : int'($urandom));
    end
    vals.sort();
    foreach (vals[i]) begin
      if ($urandom_range(24) == 0) begin
        send_item(OP_UNUSED, $urandom);
      end
      if ($urandom_range(39) == 0) begin
        send_item(OP_APPEND, $urandom);
      end
      send_item(OP_APPEND, vals[i]);
    end
    m = $urandom_range(12, 2);
    for (int j = 0; j < m; j++) begin
      pick = $urandom_range(99);
      if (vals.size() != 0 && pick < 60) begin
        key = vals[$urandom_range(vals.size() - 1)];
      end else if (vals.size() != 0 && pick < 80) begin
        key = vals[$urandom_range(vals.size() - 1)] + ($urandom_range(1) ? 1 : -1);
      end else if (pick < 90) begin
        key = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      end else begin
        key = $urandom;
      end
      send_item(OP_SEARCH, key);
    end
  endtask

  // Fill the store past its depth, then search across the whole range.
  task automatic fill_store();
    int fill_vals [$];
    int acc;
    int idx;
    send_item(OP_CLEAR, $urandom);
    acc = -1_000_000_000 + int'($urandom_range(1000));
    for (int i = 0; i < STORE_DEPTH + 6; i++) begin
      fill_vals.push_back(acc);
      send_item(OP_APPEND, acc);
      acc = acc + int'($urandom_range(1000, 1));
    end
    send_item(OP_SEARCH, fill_vals[STORE_DEPTH - 1]);
    send_item(OP_SEARCH, fill_vals[STORE_DEPTH]);
    send_item(OP_SEARCH, fill_vals[0]);
    send_item(OP_SEARCH, fill_vals[STORE_DEPTH / 2]);
    send_item(OP_SEARCH, 32'h7fff_ffff);
    send_item(OP_SEARCH, 32'h8000_0000);
    for (int j = 0; j < 34; j++) begin
      idx = $urandom_range(STORE_DEPTH - 1);
      send_item(OP_SEARCH, fill_vals[idx] + ($urandom_range(3) == 0 ? 1 : 0));
    end
  endtask

  // Stimulus.
  initial begin : stimulus
    int unsigned target;
    req.valid      = 1'b0;
    req.op         = OP_APPEND;
    req.value      = '0;
    resp.ready     = 1'b0;
    rst            = 1'b1;
    model_count    = 0;
    mismatches     = 0;
    cycle_count    = 0;
    items_sent     = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    hold_req       = 1'b0;
    hold_left      = 0;
    typed_on       = 1'b0;
    typed_found    = 1'b0;
    typed_position = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table.
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].typed,
                directed_rows[i].found, directed_rows[i].position);
    end

    // Random phases, each started from a drained block.
    for (int ph = 0; ph < 5; ph++) begin
      wait_drain();
      case (ph)
        0: set_idling(0, 0);
        1: set_idling(67, 0);
        2: set_idling(0, 67);
        3: set_idling(14, 14);
        default: set_idling(0, 0);
      endcase
      if (ph == 4) begin
        fill_store();
      end else begin
        target = items_sent + 175;
        while (items_sent < target) begin
          run_sorted_batch();
        end
      end
      // Long receiver hold-off while searches keep coming, to back up the input.
      if (ph == 0) begin
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
        for (int k = 0; k < 12; k++) begin
          send_item(OP_SEARCH, $urandom);
        end
      end
    end

    wait_drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
